FILE: hdl/pipc_pkg.sv
`default_nettype none

package pipc_pkg;

    // Storage and arithmetic sizing
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // Port field widths
    localparam int OPC_W   = 1;
    localparam int VIDX_W  = 6;
    localparam int FIELD_W = 16;
    localparam int CNT_W   = 7;
    localparam int TOL_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 1;

    // Datapath widths
    localparam int DIF_W = COORD_BITS + 1;
    localparam int P_W   = 2 * DIF_W;
    localparam int DET_W = P_W + 1;
    localparam int CMP_W = (DET_W > TOL_W + 1) ? DET_W : TOL_W + 2;
    localparam int RAM_W = 2 * COORD_BITS;

    // Operation codes
    localparam logic [OPC_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OPC_W-1:0] OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFGI_W-1:0] REG_COLLINEAR_TOL = 1'd1;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd3;
    localparam logic [CNT_W-1:0] MIN_VERTICES = 7'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD0,
        S_LOAD,
        S_MUL1,
        S_MUL2,
        S_SUB,
        S_CHECK
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/pipc_ram.sv
`default_nettype none

module pipc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/point_in_convex_polygon.sv
`default_nettype none

// Convex polygon point test.
// Commands enter on start while busy is low. opcode OP_WRITE stores the
// vertex (x_coord, y_coord) at vertex_index and gives no result;
// the block stays ready. opcode OP_QUERY tests the point against the stored
// polygon of vertex_count vertices and returns one o_inside_res, marked by a
// one-cycle o_res_valid strobe; the receiver cannot stall it.
// A query walks the closing edge and then each consecutive edge through one
// shared signed multiplier; each edge steps through difference, two products,
// det subtract and tolerance check. The walk may end early on the first
// failing edge. A count below three answers in the cycle after acceptance.
// busy is high for the whole walk. The vertex store is a single RAM with one
// read port: one vertex fetch per edge, plus the last vertex fetched up
// front. It has no reset; vertices must be written before they are queried.
// Registers are written on i_cfg_we; the user must write them only while
// idle, which the block does not enforce. Synchronous active-low reset
// returns to idle with vertex_count 3 and collinear_tolerance 0.

module point_in_convex_polygon (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [pipc_pkg::OPC_W-1:0]   i_opcode,
    input  wire logic [pipc_pkg::VIDX_W-1:0]  i_vertex_index,
    input  wire logic signed [pipc_pkg::FIELD_W-1:0] i_x_coord,
    input  wire logic signed [pipc_pkg::FIELD_W-1:0] i_y_coord,
    output logic                              o_res_valid,
    output logic                              o_inside_res,
    input  wire logic                         i_cfg_we,
    input  wire logic [pipc_pkg::CFGI_W-1:0]  i_cfg_index,
    input  wire logic [pipc_pkg::CFG_W-1:0]   i_cfg_data
);

    import pipc_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_vcount;
    logic [TOL_W-1:0] r_tol;

    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_edge, n_edge;
    logic             r_first_neg, n_first_neg;
    logic             r_res_valid, n_res_valid;
    logic             r_inside, n_inside;

    logic signed [COORD_BITS-1:0] r_px, r_py, r_ux, r_uy;
    logic signed [DIF_W-1:0]      r_dirx, r_diry, r_difx, r_dify;
    logic signed [P_W-1:0]        r_p1, r_p2;
    logic signed [DET_W-1:0]      r_det;

    logic                     accept;
    logic                     ram_we, ram_re;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [RAM_W-1:0]         ram_rdata;
    logic signed [COORD_BITS-1:0] in_x, in_y, rd_x, rd_y;
    logic [31:0]              widx, raddr_wide, n_eff_wide;
    logic [CNT_W-1:0]         n_eff;
    logic                     last_edge;

    logic signed [DIF_W-1:0]  mul_a, mul_b;
    logic signed [P_W-1:0]    mul_p;

    logic signed [CMP_W-1:0]  det_c, tol_c;
    logic                     det_pos, det_neg;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Coordinate wrap to COORD_BITS
    assign in_x = COORD_BITS'(32'(i_x_coord));
    assign in_y = COORD_BITS'(32'(i_y_coord));
    assign rd_x = $signed(ram_rdata[COORD_BITS-1:0]);
    assign rd_y = $signed(ram_rdata[RAM_W-1:COORD_BITS]);

    // Vertex store write
    assign widx      = 32'(i_vertex_index);
    assign ram_we    = accept && (i_opcode == OP_WRITE) && (widx < 32'(MAX_VERTICES));
    assign ram_waddr = widx[ADDR_W-1:0];

    pipc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({in_y, in_x}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Saturated vertex count
    assign n_eff_wide = (32'(r_vcount) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                            : 32'(r_vcount);
    assign n_eff      = n_eff_wide[CNT_W-1:0];
    assign last_edge  = (r_edge == r_n - CNT_W'(1));

    // Shared multiplier
    assign mul_a = (r_state == S_MUL1) ? r_dirx : r_diry;
    assign mul_b = (r_state == S_MUL1) ? r_dify : r_difx;
    assign mul_p = P_W'(mul_a) * P_W'(mul_b);

    // Tolerance test on the registered det
    assign det_c   = CMP_W'(r_det);
    assign tol_c   = $signed(CMP_W'(r_tol));
    assign det_pos = det_c > tol_c;
    assign det_neg = det_c < -tol_c;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_VERTEX_COUNT:  r_vcount <= i_cfg_data[CNT_W-1:0];
                REG_COLLINEAR_TOL: r_tol    <= i_cfg_data[TOL_W-1:0];
                default:           r_tol    <= r_tol;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_opcode == OP_QUERY) && (n_eff >= MIN_VERTICES)) begin
                    n_state = S_LOAD0;
                end
            end
            S_LOAD0: n_state = S_LOAD;
            S_LOAD:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUB;
            S_SUB:   n_state = S_CHECK;
            S_CHECK: begin
                priority if (!(det_pos || det_neg)) begin
                    n_state = S_IDLE;
                end else if ((r_edge != '0) && (det_neg != r_first_neg)) begin
                    n_state = S_IDLE;
                end else if (last_edge) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and control updates
    always_comb begin
        n_n         = r_n;
        n_edge      = r_edge;
        n_first_neg = r_first_neg;
        n_res_valid = 1'b0;
        n_inside    = r_inside;
        ram_re      = 1'b0;
        raddr_wide  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_opcode == OP_QUERY)) begin
                    if (n_eff >= MIN_VERTICES) begin
                        n_n        = n_eff;
                        n_edge     = '0;
                        ram_re     = 1'b1;
                        raddr_wide = 32'(n_eff - CNT_W'(1));
                    end else begin
                        n_res_valid = 1'b1;
                        n_inside    = 1'b0;
                    end
                end
            end
            S_LOAD0: begin
                // first edge ends at vertex zero
                ram_re     = 1'b1;
                raddr_wide = '0;
            end
            S_MUL2: begin
                // prefetch the end vertex of the next edge
                ram_re     = !last_edge;
                raddr_wide = 32'(r_edge + CNT_W'(1));
            end
            S_CHECK: begin
                priority if (!(det_pos || det_neg)) begin
                    n_res_valid = 1'b1;
                    n_inside    = 1'b0;
                end else if ((r_edge != '0) && (det_neg != r_first_neg)) begin
                    n_res_valid = 1'b1;
                    n_inside    = 1'b0;
                end else if (last_edge) begin
                    n_res_valid = 1'b1;
                    n_inside    = 1'b1;
                end else begin
                    n_edge = r_edge + CNT_W'(1);
                end
                if (r_edge == '0) begin
                    n_first_neg = det_neg;
                end
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign ram_raddr = raddr_wide[ADDR_W-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_edge      <= '0;
            r_first_neg <= 1'b0;
            r_res_valid <= 1'b0;
            r_inside    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_edge      <= n_edge;
            r_first_neg <= n_first_neg;
            r_res_valid <= n_res_valid;
            r_inside    <= n_inside;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= in_x;
            r_py <= in_y;
        end
        if (r_state == S_LOAD0) begin
            r_ux <= rd_x;
            r_uy <= rd_y;
        end
        if (r_state == S_LOAD) begin
            r_dirx <= DIF_W'(rd_x) - DIF_W'(r_ux);
            r_diry <= DIF_W'(rd_y) - DIF_W'(r_uy);
            r_difx <= DIF_W'(r_px) - DIF_W'(r_ux);
            r_dify <= DIF_W'(r_py) - DIF_W'(r_uy);
            r_ux   <= rd_x;
            r_uy   <= rd_y;
        end
        if (r_state == S_MUL1) begin
            r_p1 <= mul_p;
        end
        if (r_state == S_MUL2) begin
            r_p2 <= mul_p;
        end
        if (r_state == S_SUB) begin
            r_det <= DET_W'(r_p1) - DET_W'(r_p2);
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_inside_res = r_inside;

    // Result strobe only when the walk has ended
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobe while busy");

    // A walk starts only from an accepted query
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_opcode == OP_QUERY)))
        else $error("walk started without a query");

    // Edge counter stays within the polygon
    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_edge < r_n))
        else $error("edge counter out of range");

    // The store port never reads and writes in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store read and write collide");

endmodule

`default_nettype wire
